// ===== rtl/core/bsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bsp_pkg;
  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W = 8;

  typedef enum logic [2:0] {
    OP_BITS = 3'd0, OP_RANGED = 3'd1, OP_ALIGN = 3'd2, OP_FLUSH = 3'd3,
    OP_STORE = 3'd4, OP_FETCH = 3'd5, OP_RESTART = 3'd6, OP_BAD = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_OVERFLOW = 2'd1, ERR_RANGE = 2'd2, ERR_INVALID = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0, MODE_READ = 2'd1, MODE_MEASURE = 2'd2, MODE_NONE = 2'd3
  } mode_t;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_CAP = 1'b1;

  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         bit_count;
    logic [31:0]        pack_value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [7:0]         word_address;
    logic [31:0]        word_data;
  } in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  error_code;
    logic [13:0] bits_used;
    logic [8:0]  words_used;
  } out_t;

  // classified op from the front part
  typedef struct packed {
    op_t         op;
    logic        bad_width;  // raw bits width out of range, or unknown op
    logic        range_err;  // empty range or ranged write out of bounds
    logic [5:0]  bits;       // field width (raw or ranged)
    logic [31:0] value;      // value to pack (already offset)
    logic [31:0] lo;
    logic [31:0] hi;
    logic [7:0]  addr;
    logic [31:0] data;
  } cmd_t;

  function automatic logic [31:0] swap_bytes(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/bit_stream_packer_top.sv =====
// bit_stream_packer_top: packs/unpacks 1..32-bit fields against a
// 256-word store.
// Channels: in (valid/ready, in_t word), out (valid/ready, out_t word),
// cfg (valid/ready, index 0 = stream mode, 1 = capacity in words).
// Each input word gives exactly one output word, in order.
// From input accept to output valid a word passes the input and classify
// registers, one queue slot and the back stage register; stalls can hold it there.
// Throughput: one word per cycle while out is not stalled, set by the back
// stage that updates scratch, fill and cursor.
// Reset clears the scratch and cursors, mode 0, capacity 256; the store
// holds undefined data until written.
// When out is stalled the back stage holds, the queue fills, then the
// front stops and in_ready drops. Writing the mode restarts the stream.
// The user must write config only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module bit_stream_packer_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bsp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bsp_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_index,
  input  wire logic [8:0]    cfg_data
);
  import bsp_pkg::*;

  logic [1:0] mode;
  logic [8:0] capacity;
  logic       restart;
  logic       fq_valid, fq_ready, bq_valid, bq_ready;
  cmd_t       fq_cmd, bq_cmd;

  assign cfg_ready = 1'b1;
  assign restart = cfg_valid && cfg_index == CFG_MODE;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_WRITE;
      capacity <= 9'(STORE_DEPTH);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MODE) mode <= cfg_data[1:0];
      else capacity <= cfg_data;
    end
  end

  bsp_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data, .mode,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd)
  );

  bsp_queue u_queue (
    .clk, .rst, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_cmd(fq_cmd),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_cmd(bq_cmd)
  );

  bsp_back u_back (
    .clk, .rst, .cmd_valid(bq_valid), .cmd_ready(bq_ready), .cmd(bq_cmd),
    .mode, .capacity, .restart, .out_valid, .out_ready, .out_data
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out word dropped while stalled");
  a_bits_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.bits_used <= 14'(capacity) * 14'd32 || capacity > 9'(STORE_DEPTH)
    || out_data.bits_used <= 14'(STORE_DEPTH * 32))
    else $error("bit position past capacity");
  a_q_flow: assert property (@(posedge clk) disable iff (rst)
    fq_valid && !fq_ready |=> fq_valid && $stable(fq_cmd))
    else $error("front lost a command");
endmodule
`default_nettype wire

// ===== rtl/core/bsp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bsp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bsp_pkg::in_t  in_data,
  input  wire logic [1:0]    mode,
  output logic               q_valid,
  input  wire logic          q_ready,
  output bsp_pkg::cmd_t      q_cmd
);
  import bsp_pkg::*;

  // stage 1: register input; stage 2: width search and bounds
  logic  s1_valid;
  in_t   s1;
  logic  s1_adv;
  cmd_t  c;
  logic signed [32:0] lo_x, hi_x, v_x;
  logic [32:0] span;
  logic [5:0]  msb;

  assign s1_adv = !q_valid || q_ready;
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      q_valid  <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s1_adv) q_valid <= s1_valid;
    end
    if (in_ready && in_valid) s1 <= in_data;
    if (s1_adv && s1_valid) q_cmd <= c;
  end

  always_comb begin
    lo_x = {s1.range_low[31], s1.range_low};
    hi_x = {s1.range_high[31], s1.range_high};
    v_x  = {s1.pack_value[31], s1.pack_value};
    span = 33'(hi_x - lo_x);
    msb = 6'd1;
    for (int i = 1; i < 32; i++) begin
      if (span[i]) msb = 6'(i + 1);
    end
    c.op = op_t'(s1.operation);
    c.lo = s1.range_low;
    c.hi = s1.range_high;
    c.addr = s1.word_address;
    c.data = s1.word_data;
    c.bad_width = (c.op == OP_BAD) ||
                  (c.op == OP_BITS && (s1.bit_count == 6'd0 || s1.bit_count > 6'd32));
    c.range_err = 1'b0;
    c.bits = s1.bit_count;
    c.value = s1.pack_value;
    if (c.op == OP_RANGED) begin
      c.bits = msb;
      c.value = 32'(v_x - lo_x);
      if (lo_x >= hi_x) c.range_err = 1'b1;
      else if (mode == MODE_WRITE && (v_x < lo_x || v_x > hi_x)) c.range_err = 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/bsp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bsp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire bsp_pkg::cmd_t wr_cmd,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output bsp_pkg::cmd_t      rd_cmd
);
  import bsp_pkg::*;

  cmd_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_cmd = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= !wp;
      if (rd_valid && rd_ready) rp <= !rp;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
    if (wr_valid && wr_ready) mem[wp] <= wr_cmd;
  end
endmodule
`default_nettype wire

// ===== rtl/core/bsp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bsp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire bsp_pkg::cmd_t cmd,
  input  wire logic [1:0]    mode,
  input  wire logic [8:0]    capacity,
  input  wire logic          restart,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bsp_pkg::out_t      out_data
);
  import bsp_pkg::*;

  logic [31:0] store [STORE_DEPTH];
  logic [63:0] scratch, scratch_next;
  logic [6:0]  fill, fill_next;
  logic [8:0]  cursor, cursor_next;
  logic [13:0] bitpos, bitpos_next;
  logic [8:0]  cap;
  logic [31:0] got;
  err_t        err;
  logic        st_we;
  logic [7:0]  st_addr;
  logic [31:0] st_data;
  logic        fire;
  logic        commit;
  logic        is_field;
  logic [5:0]  fbits;
  logic [31:0] fval;
  logic [63:0] mask;
  logic signed [33:0] rsum;
  logic [31:0] rword;
  logic [7:0]  rd_addr;
  logic        fetch_pend;
  logic [31:0] fetch_q;
  out_t        res;
  out_t        out_q;

  assign cmd_ready = !out_valid || out_ready;
  assign fire = cmd_valid && cmd_ready;
  assign cap = (capacity > 9'(STORE_DEPTH)) ? 9'(STORE_DEPTH) : capacity;

  always_comb begin
    scratch_next = scratch;
    fill_next = fill;
    cursor_next = cursor;
    bitpos_next = bitpos;
    got = '0;
    err = ERR_NONE;
    st_we = 1'b0;
    st_addr = cursor[ADDR_W-1:0];
    st_data = swap_bytes(scratch[31:0]);
    is_field = 1'b0;
    fbits = cmd.bits;
    fval = cmd.value;
    rsum = '0;
    case (cmd.op)
      OP_BITS: begin
        if (cmd.bad_width) err = ERR_INVALID;
        else is_field = 1'b1;
      end
      OP_RANGED: begin
        if (mode == MODE_NONE) err = ERR_INVALID;
        else if (cmd.range_err) err = ERR_RANGE;
        else is_field = 1'b1;
        if (mode != MODE_WRITE) fval = '0;
      end
      OP_ALIGN: begin
        fbits = 6'((4'd8 - {1'b0, bitpos[2:0]}) & 4'd7);
        fval = '0;
        if (mode == MODE_NONE) err = ERR_INVALID;
        else if (fbits != 6'd0) is_field = 1'b1;
      end
      OP_FLUSH: begin
        if (mode != MODE_WRITE) err = ERR_INVALID;
        else if (fill != 7'd0) begin
          if (cursor >= cap) err = ERR_OVERFLOW;
          else begin
            st_we = 1'b1;
            cursor_next = cursor + 9'd1;
            scratch_next = {32'd0, scratch[63:32]};
            fill_next = (fill > 7'd32) ? fill - 7'd32 : 7'd0;
          end
        end
      end
      OP_STORE: begin
        st_we = 1'b1;
        st_addr = cmd.addr;
        st_data = cmd.data;
      end
      OP_FETCH: ;
      OP_RESTART: begin
        scratch_next = '0;
        fill_next = '0;
        cursor_next = '0;
        bitpos_next = '0;
      end
      default: err = ERR_INVALID;
    endcase

    mask = (64'd1 << fbits) - 64'd1;
    if (is_field) begin
      if (mode == MODE_NONE) err = ERR_INVALID;
      else if (({1'b0, bitpos} + 15'(fbits)) > {1'b0, cap, 5'd0}) err = ERR_OVERFLOW;
      else if (mode == MODE_MEASURE) bitpos_next = bitpos + 14'(fbits);
      else if (mode == MODE_WRITE) begin
        if (fill + 7'(fbits) >= 7'd32 && cursor >= cap) err = ERR_OVERFLOW;
        else begin
          scratch_next = scratch | (({32'd0, fval} & mask) << fill[4:0]);
          fill_next = fill + 7'(fbits);
          if (fill_next >= 7'd32) begin
            st_we = 1'b1;
            st_data = swap_bytes(scratch_next[31:0]);
            scratch_next = {32'd0, scratch_next[63:32]};
            fill_next = fill_next - 7'd32;
            cursor_next = cursor + 9'd1;
          end
          bitpos_next = bitpos + 14'(fbits);
        end
      end else begin
        if (fill < 7'(fbits) && cursor >= cap) err = ERR_OVERFLOW;
        else begin
          if (fill < 7'(fbits)) begin
            scratch_next = scratch | ({32'd0, swap_bytes(rword)} << fill[4:0]);
            fill_next = fill + 7'd32;
            cursor_next = cursor + 9'd1;
          end
          got = 32'(scratch_next & mask);
          scratch_next = scratch_next >> fbits;
          fill_next = fill_next - 7'(fbits);
          bitpos_next = bitpos + 14'(fbits);
          if (cmd.op == OP_RANGED) begin
            // decoded value may run past range_high; bits stay consumed
            rsum = $signed({{2{cmd.lo[31]}}, cmd.lo}) + $signed({2'b00, got});
            got = cmd.lo + got;
            if (rsum > $signed({{2{cmd.hi[31]}}, cmd.hi})) err = ERR_RANGE;
          end
        end
      end
    end
    if (cmd.op == OP_ALIGN) got = '0;
    if ((cmd.op == OP_STORE || cmd.op == OP_FETCH) && cmd.addr >= 8'(STORE_DEPTH - 1) + 8'd1
        && STORE_DEPTH < 256) begin
      err = ERR_OVERFLOW;
      st_we = 1'b0;
    end
    commit = (err == ERR_NONE) ||
             (is_field && cmd.op == OP_RANGED && mode == MODE_READ && err == ERR_RANGE);
    res.read_value = got;
    res.error_code = err;
    res.bits_used = commit ? bitpos_next : bitpos;
    res.words_used = commit ? cursor_next : cursor;
  end

  // word at the cursor as it stands after this edge, held in a register
  always_comb begin
    if (rst || restart) rd_addr = '0;
    else if (fire && commit) rd_addr = cursor_next[ADDR_W-1:0];
    else rd_addr = cursor[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      scratch <= '0;
      fill <= '0;
      cursor <= '0;
      bitpos <= '0;
    end else if (fire && commit) begin
      scratch <= scratch_next;
      fill <= fill_next;
      cursor <= cursor_next;
      bitpos <= bitpos_next;
    end
    if (rst) begin
      out_valid <= 1'b0;
      fetch_pend <= 1'b0;
    end else begin
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (fire) fetch_pend <= (cmd.op == OP_FETCH);
    end
    if (fire) out_q <= res;
    if (fire && commit && st_we) store[st_addr] <= st_data;
    if (fire && commit && st_we && st_addr == rd_addr) rword <= st_data;
    else rword <= store[rd_addr];
    if (fire && cmd.op == OP_FETCH) fetch_q <= store[cmd.addr];
  end

  // fetched word comes from the registered read
  always_comb begin
    out_data = out_q;
    if (fetch_pend) out_data.read_value = fetch_q;
  end
endmodule
`default_nettype wire

// ===== tb/tb_bit_stream_packer_top.sv =====
`timescale 1ns / 1ps
module tb_bit_stream_packer_top;
  import bsp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;

  bit_stream_packer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // packer state as seen by the checker
  mode_t pk_mode;
  int pk_cap_reg;
  logic [63:0] pk_scratch;
  int pk_fill, pk_cursor, pk_bitpos;
  logic [31:0] pk_store [STORE_DEPTH];

  out_t pending_words [$];
  int fail_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int idle_on = 1;
  int stall_cycles = 0;

  function automatic int pk_usable();
    return (pk_cap_reg > STORE_DEPTH) ? STORE_DEPTH : pk_cap_reg;
  endfunction

  function automatic void pk_restart();
    pk_scratch = '0;
    pk_fill = 0;
    pk_cursor = 0;
    pk_bitpos = 0;
  endfunction

  function automatic err_t pk_move(input logic [31:0] value, input int bits,
                                   output logic [31:0] got);
    int cap;
    logic [63:0] mask;
    logic [31:0] lw;
    cap = pk_usable();
    mask = (64'd1 << bits) - 64'd1;
    got = '0;
    if (pk_mode == MODE_NONE) return ERR_INVALID;
    if (pk_bitpos + bits > cap * 32) return ERR_OVERFLOW;
    if (pk_mode == MODE_MEASURE) begin
      pk_bitpos += bits;
      return ERR_NONE;
    end
    if (pk_mode == MODE_WRITE) begin
      if (pk_fill + bits >= 32 && pk_cursor >= cap) return ERR_OVERFLOW;
      pk_scratch |= ({32'd0, value} & mask) << (pk_fill % 32);
      pk_fill += bits;
      if (pk_fill >= 32) begin
        lw = pk_scratch[31:0];
        pk_store[pk_cursor] = swap_bytes(lw);
        pk_scratch >>= 32;
        pk_fill -= 32;
        pk_cursor++;
      end
    end else begin
      if (pk_fill < bits) begin
        if (pk_cursor >= cap) return ERR_OVERFLOW;
        lw = pk_store[pk_cursor];
        pk_scratch |= {32'd0, swap_bytes(lw)} << (pk_fill % 32);
        pk_fill += 32;
        pk_cursor++;
      end
      got = pk_scratch[31:0] & mask[31:0];
      pk_scratch >>= bits;
      pk_fill -= bits;
    end
    pk_bitpos += bits;
    return ERR_NONE;
  endfunction

  function automatic out_t pk_step(input in_t w);
    out_t r;
    err_t err;
    logic [31:0] got, rel, lw;
    longint lo, hi, span, v;
    int bits, pad;
    err = ERR_NONE;
    got = '0;
    case (op_t'(w.operation))
      OP_BITS: begin
        if (w.bit_count == 0 || w.bit_count > 32) err = ERR_INVALID;
        else err = pk_move(w.pack_value, int'(w.bit_count), got);
      end
      OP_RANGED: begin
        lo = longint'($signed(w.range_low));
        hi = longint'($signed(w.range_high));
        if (pk_mode == MODE_NONE) err = ERR_INVALID;
        else if (lo >= hi) err = ERR_RANGE;
        else begin
          span = hi - lo;
          bits = 1;
          for (longint s = span >> 1; s != 0; s >>= 1) bits++;
          if (pk_mode == MODE_WRITE) begin
            v = longint'($signed(w.pack_value));
            if (v < lo || v > hi) err = ERR_RANGE;
            else err = pk_move(32'(v - lo), bits, rel);
          end else if (pk_mode == MODE_MEASURE) begin
            err = pk_move('0, bits, rel);
          end else begin
            err = pk_move('0, bits, rel);
            if (err == ERR_NONE) begin
              v = lo + longint'({32'd0, rel});
              got = v[31:0];
              if (v > hi) err = ERR_RANGE;
            end
          end
        end
      end
      OP_ALIGN: begin
        pad = (8 - (pk_bitpos % 8)) % 8;
        if (pk_mode == MODE_NONE) err = ERR_INVALID;
        else if (pad != 0) err = pk_move('0, pad, got);
        got = '0;
      end
      OP_FLUSH: begin
        if (pk_mode != MODE_WRITE) err = ERR_INVALID;
        else if (pk_fill > 0) begin
          if (pk_cursor >= pk_usable()) err = ERR_OVERFLOW;
          else begin
            lw = pk_scratch[31:0];
            pk_store[pk_cursor] = swap_bytes(lw);
            pk_cursor++;
            pk_scratch >>= 32;
            pk_fill = (pk_fill > 32) ? pk_fill - 32 : 0;
          end
        end
      end
      OP_STORE: pk_store[w.word_address] = w.word_data;
      OP_FETCH: got = pk_store[w.word_address];
      OP_RESTART: pk_restart();
      default: err = ERR_INVALID;
    endcase
    r.read_value = got;
    r.error_code = err;
    r.bits_used = 14'(pk_bitpos);
    r.words_used = 9'(pk_cursor);
    return r;
  endfunction

  function automatic in_t mk(input op_t op, input logic [5:0] bc, input logic [31:0] wv,
                             input logic [31:0] lo, input logic [31:0] hi,
                             input logic [7:0] addr, input logic [31:0] data);
    in_t w;
    w.operation = op;
    w.bit_count = bc;
    w.pack_value = wv;
    w.range_low = lo;
    w.range_high = hi;
    w.word_address = addr;
    w.word_data = data;
    return w;
  endfunction

  function automatic in_t rand_word();
    in_t w;
    int pick;
    longint lo, hi, span;
    w.operation = OP_BITS;
    w.bit_count = 6'($urandom_range(1, 32));
    w.pack_value = $urandom;
    w.range_low = $urandom;
    w.range_high = $urandom;
    w.word_address = 8'($urandom);
    w.word_data = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      w.operation = OP_BITS;
      if ($urandom_range(0, 19) == 0) w.bit_count = 6'($urandom);
    end else if (pick < 72) begin
      w.operation = OP_RANGED;
      lo = longint'($signed(w.range_low));
      case ($urandom_range(0, 3))
        0: span = $urandom_range(1, 7);
        1: span = longint'($urandom_range(1, 32'(1 << $urandom_range(1, 31))));
        2: begin
          lo = -64'sd2147483648;
          span = 64'd4294967295;
        end
        default: span = longint'($signed(w.range_high)) - lo;
      endcase
      hi = lo + span;
      if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      w.range_low = lo[31:0];
      w.range_high = hi[31:0];
      if (hi > lo && $urandom_range(0, 99) < 85)
        w.pack_value = 32'(lo + (longint'($urandom) % (hi - lo + 1)));
    end else if (pick < 80) w.operation = OP_ALIGN;
    else if (pick < 87) w.operation = OP_FLUSH;
    else if (pick < 91) w.operation = OP_STORE;
    else if (pick < 95) w.operation = OP_FETCH;
    else if (pick < 98) w.operation = OP_RESTART;
    else w.operation = OP_BAD;
    return w;
  endfunction

  // send one word; expectation recorded at the accepting edge
  task automatic push_word(input in_t w, input bit typed, input out_t want);
    out_t r;
    while (idle_on && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    r = pk_step(w);
    pending_words.push_back(typed ? want : r);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MODE) begin
      pk_mode = mode_t'(val[1:0]);
      pk_restart();
    end else begin
      pk_cap_reg = int'(val);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= !idle_on || ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_data.read_value !== want.read_value) begin
          $display("%0t: read_value exp %h got %h", $time, want.read_value,
                   out_data.read_value);
          fail_count++;
        end
        if (out_data.error_code !== want.error_code) begin
          $display("%0t: error_code exp %0d got %0d", $time, want.error_code,
                   out_data.error_code);
          fail_count++;
        end
        if (out_data.bits_used !== want.bits_used) begin
          $display("%0t: bits_used exp %0d got %0d", $time, want.bits_used,
                   out_data.bits_used);
          fail_count++;
        end
        if (out_data.words_used !== want.words_used) begin
          $display("%0t: words_used exp %0d got %0d", $time, want.words_used,
                   out_data.words_used);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      stall_cycles <= 0;
    else if (stall_cycles >= 5000) begin
      $display("timeout: no word moved for %0d cycles", stall_cycles);
      $display("FAIL bit_stream_packer_top");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  typedef struct {
    in_t w;
    bit typed;
    out_t want;
  } row_t;

  row_t rows [$];

  initial begin
    out_t z, inv, rng;
    row_t rw;
    logic [1:0] modes [12] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd3,
                               2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};
    int caps [12] = '{256, 256, 256, 1, 1, 256, 0, 300, 511, 5, 17, 40};
    z = '0;
    inv = '0;
    inv.error_code = ERR_INVALID;
    rng = '0;
    rng.error_code = ERR_RANGE;

    pk_mode = MODE_WRITE;
    pk_cap_reg = 256;
    pk_restart();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole store first so no unwritten word is ever read
    for (int i = 0; i < STORE_DEPTH; i++)
      push_word(mk(OP_STORE, 0, 0, 0, 0, 8'(i), $urandom), 1'b0, z);

    // directed: fixed answers while the stream is still empty, then words checked by pk_step
    rows.push_back('{mk(OP_BITS, 0, 32'hFFFFFFFF, 0, 0, 0, 0), 1, inv});
    rows.push_back('{mk(OP_BITS, 33, 0, 0, 0, 0, 0), 1, inv});
    rows.push_back('{mk(OP_BITS, 63, 0, 0, 0, 0, 0), 1, inv});
    rows.push_back('{mk(OP_BAD, 8, 0, 0, 0, 0, 0), 1, inv});
    rows.push_back('{mk(OP_RANGED, 0, 5, 5, 5, 0, 0), 1, rng});
    rows.push_back('{mk(OP_RANGED, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0), 1, rng});
    rows.push_back('{mk(OP_RANGED, 0, 10, 0, 5, 0, 0), 1, rng});
    rows.push_back('{mk(OP_FLUSH, 0, 0, 0, 0, 0, 0), 1, z});
    rows.push_back('{mk(OP_ALIGN, 0, 0, 0, 0, 0, 0), 1, z});
    rows.push_back('{mk(OP_FETCH, 0, 0, 0, 0, 8'hFF, 0), 0, z});
    rows.push_back('{mk(OP_BITS, 1, 32'hFFFFFFFF, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(OP_BITS, 32, 32'hFFFFFFFF, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(OP_ALIGN, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(OP_BITS, 7, 32'h55, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(OP_FLUSH, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(OP_RANGED, 0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0, 0),
                     0, z});
    rows.push_back('{mk(OP_RANGED, 0, -3, -3, 4, 0, 0), 0, z});
    rows.push_back('{mk(OP_RANGED, 0, 4, -3, 4, 0, 0), 0, z});
    rows.push_back('{mk(OP_STORE, 0, 0, 0, 0, 8'hFF, 32'hFFFFFFFF), 0, z});
    rows.push_back('{mk(OP_FETCH, 0, 0, 0, 0, 8'hFF, 0), 0, z});
    rows.push_back('{mk(OP_FETCH, 0, 0, 0, 0, 8'h00, 0), 0, z});
    rows.push_back('{mk(OP_BITS, 32, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(OP_RESTART, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(OP_BITS, 5, 32'h1B, 0, 0, 0, 0), 0, z});
    foreach (rows[i]) begin
      rw = rows[i];
      push_word(rw.w, rw.typed, rw.want);
    end

    // random phases over mode and capacity settings
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      cfg_write(CFG_CAP, 9'(caps[ph]));
      cfg_write(CFG_MODE, modes[ph]);
      idle_on = (ph != 2);
      for (int i = 0; i < 40; i++) begin
        if (ph == 1 && i == 30) begin
          in_valid <= 1'b0;
          while (pending_words.size() != 0) @(posedge clk);
        end
        push_word(rand_word(), 1'b0, z);
      end
    end
    idle_on = 1;
    drain();
    repeat (20) @(posedge clk);
    if (pending_words.size() != 0) begin
      $display("%0d result words never arrived", pending_words.size());
      fail_count++;
    end
    $display("covered %0d words (%0d results) in write/read/measure/bad modes,",
             words_sent, words_checked);
    $display("capacities 0 to 511, with random stalls on both channels");
    if (fail_count == 0)
      $display("PASS bit_stream_packer_top");
    else
      $display("FAIL bit_stream_packer_top");
    $finish;
  end
endmodule
